// ===== sv/fbrr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the sine table of the framebuffer region rotator.
// Used by the controller, the datapath and the top level; depends on nothing.
package fbrr_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_COPY,
        ST_DRAIN,
        ST_PIX_FETCH,
        ST_PIX_TEST,
        ST_PIX_SUM,
        ST_PIX_READ,
        ST_PIX_WRITE,
        ST_RESULT
    } state_t;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_ROTATE = 2'd2;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;
    localparam logic [1:0] CFG_ANGLE    = 2'd3;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic acc_write;
        logic acc_read;
        logic read_latch;
        logic setup;
        logic copy_step;
        logic pix_mult;
        logic pix_sum;
        logic pix_read;
        logic pix_write;
        logic pix_advance;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic req_write;
        logic req_read;
        logic req_rotate;
        logic region_empty;
        logic bit_set;
        logic dest_ok;
        logic pix_last;
        logic out_free;
    } status_t;

    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
        15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
        15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
        15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // Sine in Q2.14 of a whole angle from 0 to 359 degrees.
    function automatic logic signed [15:0] sine_deg(input logic [8:0] a);
        logic [8:0] i;
        logic signed [15:0] v;
        if (a <= 9'd90) begin
            i = a;
            v = 16'(SIN_Q14[i[6:0]]);
        end else if (a <= 9'd180) begin
            i = 9'd180 - a;
            v = 16'(SIN_Q14[i[6:0]]);
        end else if (a <= 9'd270) begin
            i = a - 9'd180;
            v = 16'd0 - 16'(SIN_Q14[i[6:0]]);
        end else begin
            i = 9'd360 - a;
            v = 16'd0 - 16'(SIN_Q14[i[6:0]]);
        end
        return v;
    endfunction

endpackage

// ===== sv/fbrr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the framebuffer region rotator.
// Depends on fbrr_pkg; drives the datapath through cmd_t and reads status_t.
module fbrr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output fbrr_pkg::cmd_t    cmd,
    input  fbrr_pkg::status_t status
);
    import fbrr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (status.req_read) state_next = ST_READ_WAIT;
                else if (status.req_rotate) state_next = ST_COPY;
                else state_next = ST_RESULT;
            end
            ST_READ_WAIT: state_next = ST_RESULT;
            ST_COPY: begin
                if (status.sweep_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (status.region_empty) state_next = ST_RESULT;
                else state_next = ST_PIX_FETCH;
            end
            ST_PIX_FETCH: state_next = ST_PIX_TEST;
            ST_PIX_TEST: begin
                if (status.bit_set) state_next = ST_PIX_SUM;
                else if (status.pix_last) state_next = ST_RESULT;
                else state_next = ST_PIX_FETCH;
            end
            ST_PIX_SUM: state_next = ST_PIX_READ;
            ST_PIX_READ: begin
                if (status.dest_ok) state_next = ST_PIX_WRITE;
                else if (status.pix_last) state_next = ST_RESULT;
                else state_next = ST_PIX_FETCH;
            end
            ST_PIX_WRITE: begin
                if (status.pix_last) state_next = ST_RESULT;
                else state_next = ST_PIX_FETCH;
            end
            ST_RESULT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DISPATCH: begin
                cmd.acc_write = status.req_write;
                cmd.acc_read = status.req_read;
                cmd.setup = status.req_rotate;
            end
            ST_READ_WAIT: cmd.read_latch = 1'b1;
            ST_COPY: cmd.copy_step = 1'b1;
            ST_DRAIN: begin
            end
            ST_PIX_FETCH: begin
            end
            ST_PIX_TEST: begin
                cmd.pix_mult = status.bit_set;
                cmd.pix_advance = !status.bit_set;
            end
            ST_PIX_SUM: cmd.pix_sum = 1'b1;
            ST_PIX_READ: begin
                cmd.pix_read = status.dest_ok;
                cmd.pix_advance = !status.dest_ok;
            end
            ST_PIX_WRITE: begin
                cmd.pix_write = 1'b1;
                cmd.pix_advance = 1'b1;
            end
            ST_RESULT: cmd.load_result = status.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/fbrr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the framebuffer region rotator: registers, frame and snapshot
// memories, sweep and pixel counters, rotation arithmetic. Depends on fbrr_pkg.
module fbrr_datapath #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fbrr_pkg::cmd_t     cmd,
    output fbrr_pkg::status_t  status,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_wr_data,
    input  logic [23:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata
);
    import fbrr_pkg::*;

    localparam int STORE_BYTES = SCREEN_PAGES * SCREEN_COLUMNS;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W = $clog2(SCREEN_COLUMNS);
    localparam int ROWS = SCREEN_PAGES * 8;
    localparam int ROW_W = $clog2(ROWS);
    localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

    logic [6:0] center_x_reg;
    logic [5:0] center_y_reg;
    logic [5:0] radius_reg;
    logic signed [9:0] angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= 7'd64;
            center_y_reg <= 6'd32;
            radius_reg <= 6'd16;
            angle_reg <= 10'sd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_wr_data[6:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wr_data[5:0];
                CFG_RADIUS:   radius_reg <= cfg_wr_data[5:0];
                CFG_ANGLE:    angle_reg <= $signed(cfg_wr_data);
            endcase
        end
    end

    logic [1:0] req_reg;
    logic [2:0] page_reg;
    logic [6:0] col_reg;
    logic [7:0] wdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_tuser;
            page_reg <= s_tdata[2:0];
            col_reg <= s_tdata[9:3];
            wdata_reg <= s_tdata[17:10];
        end
    end

    logic acc_inside;
    logic [ADDR_W-1:0] acc_addr;

    assign acc_inside = (int'(page_reg) < SCREEN_PAGES) && (int'(col_reg) < SCREEN_COLUMNS);
    assign acc_addr = ADDR_W'(int'(page_reg) * SCREEN_COLUMNS + int'(col_reg));

    // Angle reduction, sine and cosine, and the clipped region bounds.
    logic signed [10:0] ang_a;
    logic signed [10:0] ang_b;
    logic [8:0] ang_red;
    logic [8:0] ang_cos;
    logic signed [10:0] x0s, x1s, y0s, y1s;

    always_comb begin
        ang_a = 11'(angle_reg);
        if (ang_a < 11'sd0) ang_a = ang_a + 11'sd360;
        ang_b = ang_a;
        if (ang_b < 11'sd0) ang_b = ang_b + 11'sd360;
        if (ang_b >= 11'sd360) ang_b = ang_b - 11'sd360;
        ang_red = ang_b[8:0];
        ang_cos = (ang_red >= 9'd270) ? ang_red - 9'd270 : ang_red + 9'd90;

        x0s = $signed({4'b0, center_x_reg}) - $signed({5'b0, radius_reg});
        if (x0s < 11'sd0) x0s = 11'sd0;
        x1s = $signed({4'b0, center_x_reg}) + $signed({5'b0, radius_reg}) - 11'sd1;
        if (x1s > SCREEN_COLUMNS - 1) x1s = 11'(SCREEN_COLUMNS - 1);
        y0s = $signed({5'b0, center_y_reg}) - $signed({5'b0, radius_reg});
        if (y0s < 11'sd0) y0s = 11'sd0;
        y1s = $signed({5'b0, center_y_reg}) + $signed({5'b0, radius_reg}) - 11'sd1;
        if (y1s > ROWS - 1) y1s = 11'(ROWS - 1);
    end

    logic [COL_W-1:0] x0_reg, x1_reg;
    logic [ROW_W-1:0] y0_reg, y1_reg;
    logic empty_reg;
    logic signed [15:0] sin_reg, cos_reg;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            x0_reg <= COL_W'(x0s);
            x1_reg <= COL_W'(x1s);
            y0_reg <= ROW_W'(y0s);
            y1_reg <= ROW_W'(y1s);
            empty_reg <= (x0s > x1s) || (y0s > y1s);
            sin_reg <= sine_deg(ang_red);
            cos_reg <= sine_deg(ang_cos);
        end
    end

    // Sweep over every byte, for the clearing pass and the snapshot copy.
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [PAGE_W-1:0] sweep_page_reg;
    logic [COL_W-1:0] sweep_col_reg;
    logic sweep_last;

    assign sweep_last = (sweep_addr_reg == ADDR_W'(STORE_BYTES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            sweep_page_reg <= '0;
            sweep_col_reg <= '0;
        end else if (cmd.clear_step || cmd.copy_step) begin
            if (sweep_last) begin
                sweep_addr_reg <= '0;
                sweep_page_reg <= '0;
                sweep_col_reg <= '0;
            end else begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                if (sweep_col_reg == COL_W'(SCREEN_COLUMNS - 1)) begin
                    sweep_col_reg <= '0;
                    sweep_page_reg <= sweep_page_reg + 1'b1;
                end else begin
                    sweep_col_reg <= sweep_col_reg + 1'b1;
                end
            end
        end
    end

    logic copy_wv_reg;
    logic [ADDR_W-1:0] copy_addr_reg;
    logic [PAGE_W-1:0] copy_page_reg;
    logic [COL_W-1:0] copy_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_wv_reg <= 1'b0;
        end else begin
            copy_wv_reg <= cmd.copy_step;
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= sweep_addr_reg;
        copy_page_reg <= sweep_page_reg;
        copy_col_reg <= sweep_col_reg;
    end

    logic col_in;
    logic [7:0] clear_mask;
    int row;

    always_comb begin
        col_in = (copy_col_reg >= x0_reg) && (copy_col_reg <= x1_reg) && !empty_reg;
        for (int n = 0; n < 8; n++) begin
            row = int'(copy_page_reg) * 8 + n;
            clear_mask[n] = col_in && (row >= int'(y0_reg)) && (row <= int'(y1_reg));
        end
    end

    // Pixel walk over the region.
    logic [COL_W-1:0] px_x_reg;
    logic [ROW_W-1:0] px_y_reg;
    logic pix_last;

    assign pix_last = (px_x_reg == x1_reg) && (px_y_reg == y1_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            px_x_reg <= COL_W'(x0s);
            px_y_reg <= ROW_W'(y0s);
        end else if (cmd.pix_advance) begin
            if (px_x_reg == x1_reg) begin
                px_x_reg <= x0_reg;
                if (!pix_last) px_y_reg <= px_y_reg + 1'b1;
            end else begin
                px_x_reg <= px_x_reg + 1'b1;
            end
        end
    end

    logic [ADDR_W-1:0] snap_raddr;
    logic [7:0] snap_mem [STORE_BYTES];
    logic [7:0] snap_rdata_reg;
    logic [7:0] fr_rdata_reg;

    assign snap_raddr = ADDR_W'((int'(px_y_reg) >> 3) * SCREEN_COLUMNS + int'(px_x_reg));

    always_ff @(posedge aclk) begin
        if (copy_wv_reg) snap_mem[copy_addr_reg] <= fr_rdata_reg;
        snap_rdata_reg <= snap_mem[snap_raddr];
    end

    logic signed [9:0] dx, dy;
    logic signed [25:0] prod_xc_reg, prod_ys_reg, prod_xs_reg, prod_yc_reg;

    assign dx = $signed(10'(px_x_reg)) - $signed(10'(center_x_reg));
    assign dy = $signed(10'(px_y_reg)) - $signed(10'(center_y_reg));

    always_ff @(posedge aclk) begin
        if (cmd.pix_mult) begin
            prod_xc_reg <= 26'(dx * cos_reg);
            prod_ys_reg <= 26'(dy * sin_reg);
            prod_xs_reg <= 26'(dx * sin_reg);
            prod_yc_reg <= 26'(dy * cos_reg);
        end
    end

    logic signed [27:0] sum_x, sum_y;
    logic signed [13:0] qx, qy;
    logic q_ok;

    always_comb begin
        sum_x = 28'(prod_xc_reg) - 28'(prod_ys_reg)
              + $signed({7'b0, center_x_reg, 14'b0});
        sum_y = 28'(prod_xs_reg) + 28'(prod_yc_reg)
              + $signed({8'b0, center_y_reg, 14'b0});
        qx = sum_x[27:14];
        if (sum_x[27] && (sum_x[13:0] != 14'd0)) qx = qx + 14'sd1;
        qy = sum_y[27:14];
        if (sum_y[27] && (sum_y[13:0] != 14'd0)) qy = qy + 14'sd1;
        q_ok = !qx[13] && (qx < SCREEN_COLUMNS) && !qy[13] && (qy < ROWS);
    end

    logic [COL_W-1:0] dest_x_reg;
    logic [ROW_W-1:0] dest_y_reg;
    logic dest_ok_reg;
    logic [ADDR_W-1:0] dest_addr;

    always_ff @(posedge aclk) begin
        if (cmd.pix_sum) begin
            dest_x_reg <= COL_W'(qx);
            dest_y_reg <= ROW_W'(qy);
            dest_ok_reg <= q_ok;
        end
    end

    assign dest_addr = ADDR_W'((int'(dest_y_reg) >> 3) * SCREEN_COLUMNS + int'(dest_x_reg));

    // Frame memory: one write and one registered read each cycle.
    logic [7:0] frame_mem [STORE_BYTES];
    logic [ADDR_W-1:0] fr_raddr;
    logic fr_we;
    logic [ADDR_W-1:0] fr_waddr;
    logic [7:0] fr_wdata;

    always_comb begin
        if (cmd.pix_read) fr_raddr = dest_addr;
        else if (cmd.copy_step) fr_raddr = sweep_addr_reg;
        else fr_raddr = acc_addr;

        fr_we = 1'b0;
        fr_waddr = acc_addr;
        fr_wdata = wdata_reg;
        if (cmd.clear_step) begin
            fr_we = 1'b1;
            fr_waddr = sweep_addr_reg;
            fr_wdata = 8'd0;
        end else if (copy_wv_reg) begin
            fr_we = 1'b1;
            fr_waddr = copy_addr_reg;
            fr_wdata = fr_rdata_reg & ~clear_mask;
        end else if (cmd.pix_write) begin
            fr_we = 1'b1;
            fr_waddr = dest_addr;
            fr_wdata = fr_rdata_reg | (8'd1 << dest_y_reg[2:0]);
        end else if (cmd.acc_write) begin
            fr_we = acc_inside;
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_we) frame_mem[fr_waddr] <= fr_wdata;
        fr_rdata_reg <= frame_mem[fr_raddr];
    end

    logic [7:0] rd_byte_reg;
    logic [13:0] count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.read_latch) rd_byte_reg <= acc_inside ? fr_rdata_reg : 8'd0;
        if (cmd.setup) count_reg <= '0;
        else if (cmd.pix_write) count_reg <= count_reg + 1'b1;
    end

    logic m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_tdata_reg <= {2'b00,
                            (req_reg == REQ_ROTATE) ? count_reg : 14'd0,
                            (req_reg == REQ_READ) ? rd_byte_reg : 8'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    always_comb begin
        status.sweep_last = sweep_last;
        status.req_write = (req_reg == REQ_WRITE);
        status.req_read = (req_reg == REQ_READ);
        status.req_rotate = (req_reg == REQ_ROTATE);
        status.region_empty = empty_reg;
        status.bit_set = snap_rdata_reg[px_y_reg[2:0]];
        status.dest_ok = dest_ok_reg;
        status.pix_last = pix_last;
        status.out_free = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== sv/framebuffer_region_rotator.sv =====
`timescale 1ns / 1ps
// Top level of the framebuffer region rotator: a monochrome framebuffer of
// pages of column bytes, with byte access and in-place region rotation.
// Depends on fbrr_pkg, fbrr_ctrl and fbrr_datapath.
//
// Each item on the s_ channel gives exactly one item on the m_ channel.
// A write stores a byte, a read returns one, and a rotate turns the square
// region about the configured centre by the configured angle and returns the
// number of pixels placed. Registers are written through cfg_wr_en, cfg_index
// and cfg_wr_data; the user must write them only while the block is idle,
// which the block itself does not enforce. After reset the frame memory is
// cleared one byte a cycle over all SCREEN_PAGES * SCREEN_COLUMNS bytes (1024
// by default); s_tready stays low meanwhile. Items are processed one at a
// time, and a read waits for the registered frame byte. A rotate copies the
// frame to a snapshot, one byte a cycle through the frame memory port, then
// walks the region: each pixel is fetched and tested; a set pixel is rotated
// and its destination read and, if on the screen, written. The result sits in
// an output register; a new item is accepted while it waits, and the next
// result waits until m_tready has taken the first.
module framebuffer_region_rotator #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // page[2:0], column[9:3], write_data[17:10]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], pixels_drawn[21:8]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wr_data
);
    import fbrr_pkg::*;

    cmd_t cmd;
    status_t status;

    fbrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fbrr_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== sv/fbrr_checker.sv =====
`timescale 1ns / 1ps
// Port checker of the framebuffer region rotator and its bind to the top level.
// Depends only on the top level's ports.
module fbrr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // The clearing pass follows every reset, so no item is taken at once.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("item taken straight after reset");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown straight after reset");

    // Items are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind framebuffer_region_rotator fbrr_checker u_fbrr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/framebuffer_region_rotator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the framebuffer region rotator: byte writes, reads and
// region rotations are driven and each result is compared with a local model of the frame.
// Depends on fbrr_pkg and framebuffer_region_rotator.
module framebuffer_region_rotator_tb;
    import fbrr_pkg::*;

    localparam int COLS = 128;
    localparam int ROWS = 64;
    localparam int N_BYTES = 1024;
    localparam int Q_ONE = 16384;

    typedef struct packed {
        logic [13:0] pixels_drawn;
        logic [7:0]  read_data;
    } frame_result_t;

    typedef struct {
        logic [1:0] req;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] data;
        logic       known;
        logic [7:0] exp_read;
        logic [13:0] exp_drawn;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_wr_data = '0;

    logic [7:0]  frame_copy [0:N_BYTES-1];
    logic [7:0]  snap_copy [0:N_BYTES-1];
    logic [6:0]  cx_reg;
    logic [5:0]  cy_reg;
    logic [5:0]  radius_reg;
    logic [9:0]  angle_reg;
    frame_result_t pending_results [$];
    int          fail_count = 0;
    bit          quiet_sink = 1'b0;

    framebuffer_region_rotator i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int sin_q14(input int a);
        int d;
        d = (a <= 90) ? a : (a <= 180) ? 180 - a : (a <= 270) ? a - 180 : 360 - a;
        d = $rtoi($floor(16384.0 * $sin(d * 3.14159265358979323846 / 180.0) + 0.5));
        return (a <= 180) ? d : -d;
    endfunction

    function automatic int rotate_frame();
        int ang, s, c, x0, x1, y0, y1, px, py, count, cx, cy, r;
        cx = cx_reg;
        cy = cy_reg;
        r = radius_reg;
        ang = $signed(angle_reg) % 360;
        if (ang < 0) ang += 360;
        s = sin_q14(ang);
        c = sin_q14((ang + 90) % 360);
        x0 = (cx - r < 0) ? 0 : cx - r;
        x1 = (cx + r - 1 > COLS - 1) ? COLS - 1 : cx + r - 1;
        y0 = (cy - r < 0) ? 0 : cy - r;
        y1 = (cy + r - 1 > ROWS - 1) ? ROWS - 1 : cy + r - 1;
        count = 0;
        snap_copy = frame_copy;
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
                frame_copy[(y >> 3) * COLS + x][y & 7] = 1'b0;
        for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
                if (!snap_copy[(y >> 3) * COLS + x][y & 7]) continue;
                px = ((x - cx) * c - (y - cy) * s + cx * Q_ONE) / Q_ONE;
                py = ((x - cx) * s + (y - cy) * c + cy * Q_ONE) / Q_ONE;
                if (px < 0 || px >= COLS || py < 0 || py >= ROWS) continue;
                frame_copy[(py >> 3) * COLS + px][py & 7] = 1'b1;
                count++;
            end
        end
        return count;
    endfunction

    function automatic frame_result_t predict_frame(input logic [1:0] req,
            input logic [2:0] page, input logic [6:0] column, input logic [7:0] data);
        frame_result_t r;
        r = '0;
        case (req)
            REQ_WRITE:  frame_copy[page * COLS + column] = data;
            REQ_READ:   r.read_data = frame_copy[page * COLS + column];
            REQ_ROTATE: r.pixels_drawn = 14'(rotate_frame());
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CENTER_X: cx_reg = value[6:0];
            CFG_CENTER_Y: cy_reg = value[5:0];
            CFG_RADIUS:   radius_reg = value[5:0];
            default:      angle_reg = value;
        endcase
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic send_item(input logic [1:0] req, input logic [2:0] page,
            input logic [6:0] column, input logic [7:0] data, input bit idle_ok);
        frame_result_t r;
        @(negedge aclk);
        while (idle_ok && $urandom_range(99) < 14) begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'd0, data, column, page};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_frame(req, page, column, data);
        pending_results.push_back(r);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic set_region(input int cx, input int cy, input int r, input int ang);
        settle();
        write_reg(CFG_CENTER_X, 10'(cx));
        write_reg(CFG_CENTER_Y, 10'(cy));
        write_reg(CFG_RADIUS, 10'(r));
        write_reg(CFG_ANGLE, 10'(ang));
    endtask

    always @(negedge aclk) begin
        m_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 14);
    end

    always @(posedge aclk) begin
        frame_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = frame_result_t'(m_tdata[21:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data expected %0d actual %0d", want.read_data, got.read_data);
                    fail_count++;
                end
                if (got.pixels_drawn !== want.pixels_drawn) begin
                    $error("pixels_drawn expected %0d actual %0d",
                           want.pixels_drawn, got.pixels_drawn);
                    fail_count++;
                end
            end
        end
    end

    stim_row_t directed [] = '{
        '{REQ_READ,   3'd0, 7'd0,   8'h00, 1'b1, 8'h00, 14'd0},
        '{REQ_WRITE,  3'd0, 7'd0,   8'hFF, 1'b1, 8'h00, 14'd0},
        '{REQ_READ,   3'd0, 7'd0,   8'h00, 1'b1, 8'hFF, 14'd0},
        '{REQ_WRITE,  3'd7, 7'd127, 8'hA5, 1'b1, 8'h00, 14'd0},
        '{REQ_READ,   3'd7, 7'd127, 8'h5A, 1'b1, 8'hA5, 14'd0},
        '{2'd3,       3'd7, 7'd127, 8'hFF, 1'b1, 8'h00, 14'd0},
        '{REQ_WRITE,  3'd4, 7'd64,  8'h0F, 1'b0, 8'h00, 14'd0},
        '{REQ_WRITE,  3'd3, 7'd70,  8'hF0, 1'b0, 8'h00, 14'd0},
        '{REQ_ROTATE, 3'd0, 7'd0,   8'h00, 1'b0, 8'h00, 14'd0},
        '{REQ_READ,   3'd4, 7'd64,  8'h00, 1'b0, 8'h00, 14'd0},
        '{REQ_READ,   3'd3, 7'd70,  8'h00, 1'b0, 8'h00, 14'd0}
    };

    initial begin
        int rounds;
        logic [1:0] req;
        frame_result_t r;
        for (int i = 0; i < N_BYTES; i++) frame_copy[i] = 8'h00;
        cx_reg = 7'd64;
        cy_reg = 6'd32;
        radius_reg = 6'd16;
        angle_reg = 10'd0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i].req, directed[i].page, directed[i].column,
                      directed[i].data, 1'b1);
            if (directed[i].known) begin
                r = pending_results[$];
                if (r.read_data !== directed[i].exp_read ||
                        r.pixels_drawn !== directed[i].exp_drawn) begin
                    $error("row %0d: model disagrees with table", i);
                    fail_count++;
                end
            end
        end

        // Corner centres, full and zero radius, angles at both limits.
        set_region(0, 0, 63, 360);
        send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, 1'b1);
        set_region(127, 63, 0, -360);
        send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, 1'b1);
        set_region(64, 32, 40, -90);
        send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, 1'b1);
        set_region(5, 60, 12, 511);
        send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, 1'b1);
        set_region(30, 20, 8, -512);
        send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, 1'b1);

        for (rounds = 0; rounds < 8; rounds++) begin
            set_region($urandom_range(127), $urandom_range(63), $urandom_range(20),
                       $urandom_range(1023));
            quiet_sink = (rounds == 3);
            for (int k = 0; k < 12; k++) begin
                req = ($urandom_range(9) < 6) ? REQ_WRITE : 2'($urandom_range(3));
                send_item(req, 3'($urandom), 7'($urandom), 8'($urandom), rounds != 3);
            end
            send_item(REQ_ROTATE, 3'd0, 7'd0, 8'd0, rounds != 3);
        end
        quiet_sink = 1'b0;

        settle();
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
